[sv/apeks_pkg.sv]
package apeks_pkg;

    // History depth and scan limits
    localparam int HIST_DEPTH   = 13;
    localparam int SCAN_RUN_MAX = 6;
    localparam logic [1:0] MAX_MATCHES = 2'd3;
    localparam logic [7:0] CASE_GAP    = 8'd32;

    // Key strings, last character in the least significant byte, zero-padded at the top
    localparam int KEY_MAX_LEN = 6;
    localparam logic [47:0] KEY_ALBUM  = {8'h00, "Album"};
    localparam logic [47:0] KEY_ARTIST = "Artist";
    localparam logic [47:0] KEY_TITLE  = {8'h00, "Title"};
    localparam int ALBUM_LEN  = 5;
    localparam int ARTIST_LEN = 6;
    localparam int TITLE_LEN  = 5;

    // Field codes
    localparam logic [1:0] FIELD_ALBUM  = 2'd0;
    localparam logic [1:0] FIELD_ARTIST = 2'd1;
    localparam logic [1:0] FIELD_TITLE  = 2'd2;

    // Result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_VALUES   = 1'b1;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] MAX_VALUE_LEN_RST = 16'd256;
    localparam logic        EMIT_VALUES_RST   = 1'b1;

    typedef enum logic [1:0] {
        PH_SCAN  = 2'd0,
        PH_SEP   = 2'd1,
        PH_VALUE = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_tag;
    } tag_item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  field_id;
        logic [15:0] value_length;
        logic [7:0]  data_byte;
        logic        last_of_value;
    } res_item_t;

    // Outcome of the key search on one scanned byte
    typedef struct packed {
        logic        hit;
        logic [1:0]  field;
        logic [15:0] length;
    } match_t;

endpackage

[sv/apeks_key_match.sv]
module apeks_key_match (
    input  logic [7:0]                                 cur_byte,
    input  logic [apeks_pkg::HIST_DEPTH-1:0][7:0]      hist,
    input  logic [2:0]                                 scan_run,
    input  logic [15:0]                                max_value_len,
    output apeks_pkg::match_t                          match
);
    import apeks_pkg::*;

    logic [HIST_DEPTH:0][7:0] win;
    logic        album_hit;
    logic        artist_hit;
    logic        title_hit;
    logic [31:0] album_len;
    logic [31:0] artist_len;
    logic [31:0] title_len;
    logic [31:0] sel_len;
    logic        any_hit;

    // Case-insensitive compare: equal or 32 apart either way
    function automatic logic char_match(input logic [7:0] b, input logic [7:0] k);
        char_match = (b == k) || ((b - k) == CASE_GAP) || ((k - b) == CASE_GAP);
    endfunction

    // Key ends at the current byte; character p from the end sits at win[p]
    function automatic logic key_hit(input logic [HIST_DEPTH:0][7:0] w,
                                     input logic [47:0] key, input int klen);
        logic ok;
        ok = 1'b1;
        for (int p = 0; p < KEY_MAX_LEN; p++) begin
            if (p < klen && !char_match(w[p], key[8*p +: 8]))
                ok = 1'b0;
        end
        key_hit = ok;
    endfunction

    // Little-endian length lies 8 to 5 bytes before the key start
    function automatic logic [31:0] key_len(input logic [HIST_DEPTH:0][7:0] w,
                                            input int klen);
        key_len = {w[klen+4], w[klen+5], w[klen+6], w[klen+7]};
    endfunction

    assign win = {hist, cur_byte};

    // Require the whole key to have arrived while scanning
    assign album_hit  = (scan_run >= 3'(ALBUM_LEN - 1))  && key_hit(win, KEY_ALBUM, ALBUM_LEN);
    assign artist_hit = (scan_run >= 3'(ARTIST_LEN - 1)) && key_hit(win, KEY_ARTIST, ARTIST_LEN);
    assign title_hit  = (scan_run >= 3'(TITLE_LEN - 1))  && key_hit(win, KEY_TITLE, TITLE_LEN);

    assign album_len  = key_len(win, ALBUM_LEN);
    assign artist_len = key_len(win, ARTIST_LEN);
    assign title_len  = key_len(win, TITLE_LEN);

    // Pick the first key that matched; its length decides acceptance
    always_comb
    begin
        any_hit     = 1'b1;
        match.field = FIELD_ALBUM;
        sel_len     = album_len;
        priority if (album_hit)
        begin
            match.field = FIELD_ALBUM;
            sel_len     = album_len;
        end
        else if (artist_hit)
        begin
            match.field = FIELD_ARTIST;
            sel_len     = artist_len;
        end
        else if (title_hit)
        begin
            match.field = FIELD_TITLE;
            sel_len     = title_len;
        end
        else
        begin
            any_hit = 1'b0;
        end
        match.length = sel_len[15:0];
        match.hit    = any_hit && (sel_len[31:16] == 16'd0) && (sel_len[15:0] <= max_value_len);
    end

endmodule

[sv/ape_tag_key_scanner_top.sv]
// APEv2 tag key scanner. Feed the tag body one byte per transfer on the tag
// channel, with end_of_tag on the final byte; afterwards all scan state is
// cleared while the configuration registers keep their values. For each of
// the keys Album, Artist and Title (case-insensitive) whose 32-bit length is
// at most max_value_len, a report transfer (kind 0) is produced on the
// result channel, followed, when emit_values is 1, by one data transfer
// (kind 1) per value byte with last_of_value on the final one. At most three
// keys are reported per tag. Throughput is one byte per clock: each byte is
// decoded in the cycle it is taken and its result, if any, appears in the
// result register on the next cycle. A byte is taken whenever that single
// result register is empty or is being drained in the same cycle, so
// res_ready stalls propagate to tag_ready combinationally. Configuration
// writes (index 0 max_value_len, index 1 emit_values) are always ready and
// must only be issued while the block is idle.
module ape_tag_key_scanner_top (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       tag_valid,
    output logic                                       tag_ready,
    input  apeks_pkg::tag_item_t                       tag_item,
    output logic                                       res_valid,
    input  logic                                       res_ready,
    output apeks_pkg::res_item_t                       res_item,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [apeks_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [apeks_pkg::CFG_DATA_W-1:0]           cfg_data
);
    import apeks_pkg::*;

    phase_t                        phase_reg, phase_next;
    logic [HIST_DEPTH-1:0][7:0]    hist_reg, hist_next;
    logic [15:0]                   bytes_left_reg, bytes_left_next;
    logic [1:0]                    cur_field_reg, cur_field_next;
    logic [1:0]                    matches_reg, matches_next;
    logic [2:0]                    scan_run_reg, scan_run_next;
    logic [15:0]                   max_value_len_reg;
    logic                          emit_values_reg;
    logic                          res_valid_reg;
    res_item_t                     res_item_reg, res_item_next;
    logic                          res_load;
    logic                          tag_xfer;
    logic [15:0]                   bytes_dec;
    phase_t                        resume_phase;
    match_t                        match;

    assign tag_ready = !res_valid_reg || res_ready;
    assign tag_xfer  = tag_valid && tag_ready;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    apeks_key_match u_match (
        .cur_byte      (tag_item.in_byte),
        .hist          (hist_reg),
        .scan_run      (scan_run_reg),
        .max_value_len (max_value_len_reg),
        .match         (match)
    );

    assign bytes_dec    = (bytes_left_reg != 16'd0) ? (bytes_left_reg - 16'd1) : bytes_left_reg;
    assign resume_phase = (matches_reg >= MAX_MATCHES) ? PH_DONE : PH_SCAN;

    // Next state and result for the byte on the tag channel
    always_comb
    begin
        phase_next      = phase_reg;
        hist_next       = hist_reg;
        bytes_left_next = bytes_left_reg;
        cur_field_next  = cur_field_reg;
        matches_next    = matches_reg;
        scan_run_next   = scan_run_reg;
        res_load        = 1'b0;
        res_item_next   = '0;

        if (tag_xfer)
        begin
            unique case (phase_reg)
                PH_SCAN:
                begin
                    if (match.hit)
                    begin
                        res_load                    = 1'b1;
                        res_item_next.kind          = KIND_REPORT;
                        res_item_next.field_id      = match.field;
                        res_item_next.value_length  = match.length;
                        res_item_next.last_of_value = (match.length == 16'd0);
                        cur_field_next  = match.field;
                        bytes_left_next = match.length;
                        matches_next    = matches_reg + 2'd1;
                        phase_next      = PH_SEP;
                        scan_run_next   = 3'd0;
                    end
                    else if (scan_run_reg < 3'(SCAN_RUN_MAX))
                    begin
                        scan_run_next = scan_run_reg + 3'd1;
                    end
                end
                PH_SEP:
                begin
                    // Skip the separator; on an empty value resume scanning, or stop after the third match
                    if (bytes_left_reg != 16'd0)
                    begin
                        phase_next = PH_VALUE;
                    end
                    else
                    begin
                        phase_next    = resume_phase;
                        scan_run_next = 3'd0;
                    end
                end
                PH_VALUE:
                begin
                    if (emit_values_reg)
                    begin
                        res_load                    = 1'b1;
                        res_item_next.kind          = KIND_DATA;
                        res_item_next.field_id      = cur_field_reg;
                        res_item_next.data_byte     = tag_item.in_byte;
                        res_item_next.last_of_value = (bytes_left_reg == 16'd1);
                    end
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0)
                    begin
                        phase_next    = resume_phase;
                        scan_run_next = 3'd0;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_SCAN;
                end
            endcase

            // Advance the byte history
            hist_next = {hist_reg[HIST_DEPTH-2:0], tag_item.in_byte};

            // Drop all scan state after the final byte of the tag
            if (tag_item.end_of_tag)
            begin
                phase_next      = PH_SCAN;
                hist_next       = '0;
                bytes_left_next = 16'd0;
                cur_field_next  = FIELD_ALBUM;
                matches_next    = 2'd0;
                scan_run_next   = 3'd0;
            end
        end
    end

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SCAN;
            hist_reg       <= '0;
            bytes_left_reg <= 16'd0;
            cur_field_reg  <= FIELD_ALBUM;
            matches_reg    <= 2'd0;
            scan_run_reg   <= 3'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hist_reg       <= hist_next;
            bytes_left_reg <= bytes_left_next;
            cur_field_reg  <= cur_field_next;
            matches_reg    <= matches_next;
            scan_run_reg   <= scan_run_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_len_reg <= MAX_VALUE_LEN_RST;
            emit_values_reg   <= EMIT_VALUES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_VALUE_LEN: max_value_len_reg <= cfg_data[15:0];
                CFG_EMIT_VALUES:   emit_values_reg   <= cfg_data[0];
                default:           max_value_len_reg <= max_value_len_reg;
            endcase
        end
    end

    // Result register valid: load on a producing transfer, clear when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload: hold until the next producing transfer
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_item_reg <= res_item_next;
        end
    end

endmodule
